/* hdl/ctrle_pkg.sv */
// ============================================================================
// ctrle_pkg
// Shared types and constants for the corner transform run-length encoder.
// ============================================================================
package ctrle_pkg;

  localparam int PIX_W  = 8;   // pixel width
  localparam int SYM_W  = 11;  // symbol width
  localparam int ROW_W  = 16;  // row counter width
  localparam int POS_W  = 17;  // width for position compares, holds 65536
  localparam int BEC_W  = 28;  // end-of-block counter width
  localparam int MOD_W  = 5;   // Paeth residuals are taken modulo 32

  localparam logic [BEC_W-1:0] BEC_MAX = {BEC_W{1'b1}};

  localparam int DEFAULT_MAX_WIDTH = 4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int WIDTH_W = 13;
  localparam int HEIGHT_W = 16;
  localparam int BSIZE_W = 13;
  localparam int LIMIT_W = 11;
  localparam int LOG_W = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1024;
  localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 13'd32;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd1024;
  localparam logic [LIMIT_W-1:0]  LIMIT_MAX  = 11'd1024;
  localparam logic [LOG_W-1:0]    LOG_RST    = 4'd4;
  localparam logic [LOG_W-1:0]    LOG_MAX    = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_BLOCK_SIZE     = 3'd2,
    REG_PREDICTOR_MODE = 3'd3,
    REG_SYMBOL_LIMIT   = 3'd4,
    REG_RUN_RADIX_LOG  = 3'd5,
    REG_EOB_RADIX_LOG  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_REM,
    ST_UPDATE,
    ST_EOB,
    ST_RUN,
    ST_RESID
  } state_t;

  // Current pixel (a), left (b), up-left (c) and above (d).
  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
  } nbr_t;

endpackage

/* hdl/corner_transform_run_length_encoder_core.sv */
// ============================================================================
// corner_transform_run_length_encoder_core
// Pixels arrive one word at a time in raster order and leave as a stream of
// symbol words: residuals, zero-run digits and end-of-block digits, with last
// marking the final word that a pixel causes. Each pixel is handled by a small
// sequencer and the block takes no new pixel until the words of the previous
// one have all been placed in the output register. A pixel is accepted, which
// also reads its entry of the row store; then the residual is formed, the run
// counts are updated, and the output words that it produces follow, waiting
// while the output side stalls. A zero residual that does not end a row also
// runs the serial remainder unit, which finds the column's place in its block
// one column bit per cycle. Run and end-of-block counts are split into digits
// by one shared shifter, one digit per cycle while the output register is free.
// The previous-row store needs no clearing pass: a fill count marks how many
// leading entries hold pixels of the current image, and entries beyond it
// read as zero, so the block is ready right after reset and right after the
// last pixel of an image. Configuration registers are written through a plain
// write port and should only change while the block is idle.
// ============================================================================
module corner_transform_run_length_encoder_core #(
  parameter int MAX_WIDTH = ctrle_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [ctrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ctrle_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [ctrle_pkg::PIX_W-1:0]        pixel,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [ctrle_pkg::SYM_W-1:0]        symbol,
  output logic                               error,
  output logic                               last
);

  // Column counter width; the zero run can span at most one image.
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int ZW    = CW + ctrle_pkg::ROW_W;
  localparam int SHW   = (ZW > ctrle_pkg::BEC_W) ? ZW : ctrle_pkg::BEC_W;
  localparam int CNT_W = $clog2(CW + 1);
  localparam int PW    = ctrle_pkg::POS_W;
  localparam int SW    = ctrle_pkg::SYM_W;
  localparam int BW    = ctrle_pkg::BEC_W;

  // Configuration registers.
  logic [ctrle_pkg::WIDTH_W-1:0]  image_width;
  logic [ctrle_pkg::HEIGHT_W-1:0] image_height;
  logic [ctrle_pkg::BSIZE_W-1:0]  block_size;
  logic                           predictor_mode;
  logic [ctrle_pkg::LIMIT_W-1:0]  symbol_limit;
  logic [ctrle_pkg::LOG_W-1:0]    run_radix_log;
  logic [ctrle_pkg::LOG_W-1:0]    eob_radix_log;

  // Sequencer and image position.
  ctrle_pkg::state_t state, state_next;
  logic [ctrle_pkg::PIX_W-1:0] left_px, upleft_px;
  logic [CW-1:0]               col;
  logic [ctrle_pkg::ROW_W-1:0] row;
  logic [CW:0]                 fill;
  logic [ZW-1:0]               zr;
  logic [BW-1:0]               be;

  // Per-pixel working registers.
  logic [ctrle_pkg::PIX_W-1:0] pix;
  logic [ctrle_pkg::PIX_W-1:0] row_rd;
  logic                        d_valid;
  logic [SW-1:0]               res;
  logic                        row_end_r, last_px_r;
  logic [ctrle_pkg::BSIZE_W-1:0] rem;
  logic [CW-1:0]               qsh;
  logic [CNT_W-1:0]            cnt;

  // Previous-row store.
  logic [ctrle_pkg::PIX_W-1:0] row_mem [MAX_WIDTH];

  // Effective (clamped) configuration.
  logic [ctrle_pkg::WIDTH_W-1:0]  wlim;
  logic [ctrle_pkg::HEIGHT_W-1:0] hlim;
  logic [ctrle_pkg::BSIZE_W-1:0]  bs;
  logic [ctrle_pkg::LIMIT_W-1:0]  lim;
  logic [ctrle_pkg::LOG_W-1:0]    mlog, klog;

  logic [PW-1:0] col1;
  logic          row_end, last_px;
  logic [ctrle_pkg::PIX_W-1:0] d_px;
  ctrle_pkg::nbr_t nbr;
  logic [SW-1:0] res_calc;

  logic [ctrle_pkg::BSIZE_W:0]   rem_sh;
  logic [ctrle_pkg::BSIZE_W-1:0] rem_new;
  logic                          blk_end, flush;
  logic [ZW-1:0]                 zr1;
  logic [BW-1:0]                 be1;

  logic [SHW-1:0] sh_src, sh_out;
  logic [ctrle_pkg::LOG_W-1:0] sh_log;
  logic [7:0]     dmask, digit;

  logic          slot_free, out_load;
  logic [SW-1:0] nxt_sym;
  logic          nxt_err, nxt_last;

  assign wlim = (image_width == '0) ? ctrle_pkg::WIDTH_W'(1) : image_width;
  assign hlim = (image_height == '0) ? ctrle_pkg::HEIGHT_W'(1) : image_height;
  assign bs   = (block_size == '0) ? ctrle_pkg::BSIZE_W'(1) : block_size;
  assign lim  = (symbol_limit == '0) ? ctrle_pkg::LIMIT_W'(1) :
                (symbol_limit > ctrle_pkg::LIMIT_MAX) ? ctrle_pkg::LIMIT_MAX : symbol_limit;
  assign mlog = (run_radix_log == '0) ? ctrle_pkg::LOG_W'(1) :
                (run_radix_log > ctrle_pkg::LOG_MAX) ? ctrle_pkg::LOG_MAX : run_radix_log;
  assign klog = (eob_radix_log == '0) ? ctrle_pkg::LOG_W'(1) :
                (eob_radix_log > ctrle_pkg::LOG_MAX) ? ctrle_pkg::LOG_MAX : eob_radix_log;

  // A column whose successor is at or past the clamped width ends the row; likewise for the last row.
  assign col1    = PW'(col) + PW'(1);
  assign row_end = (col1 >= PW'(wlim)) || (col1 >= PW'(MAX_WIDTH));
  assign last_px = row_end && ((PW'(row) + PW'(1)) >= PW'(hlim));

  // Entries at or beyond the fill count have not been written in this image.
  assign d_px = d_valid ? row_rd : '0;

  assign nbr.a = pix;
  assign nbr.b = left_px;
  assign nbr.c = upleft_px;
  assign nbr.d = d_px;

  ctrle_residual u_residual (
    .nbr   (nbr),
    .paeth (predictor_mode),
    .col0  (col == '0),
    .res   (res_calc)
  );

  // Restoring remainder step: one column bit per cycle, MSB first.
  assign rem_sh  = {rem, qsh[CW-1]};
  assign rem_new = (rem_sh >= {1'b0, bs}) ?
                   ctrle_pkg::BSIZE_W'(rem_sh - {1'b0, bs}) :
                   rem_sh[ctrle_pkg::BSIZE_W-1:0];

  // Run bookkeeping for the pixel in hand.
  assign blk_end = row_end_r || (rem == bs - ctrle_pkg::BSIZE_W'(1));
  assign zr1 = (res != '0) ? zr : (blk_end ? '0 : zr + ZW'(1));
  assign be1 = ((res == '0) && blk_end && (be != ctrle_pkg::BEC_MAX)) ? be + BW'(1) : be;
  assign flush = ((res != '0) && (res < SW'(lim))) || last_px_r;

  // Shared digit shifter for both counts.
  assign sh_src = (state == ctrle_pkg::ST_EOB) ? SHW'(be) : SHW'(zr);
  assign sh_log = (state == ctrle_pkg::ST_EOB) ? klog : mlog;
  assign sh_out = sh_src >> sh_log;
  assign dmask  = (8'd1 << sh_log) - 8'd1;
  assign digit  = sh_src[7:0] & dmask;

  assign slot_free   = !result_valid || result_ready;
  assign pixel_ready = (state == ctrle_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    nxt_sym    = '0;
    nxt_err    = 1'b0;
    nxt_last   = 1'b0;
    case (state)
      ctrle_pkg::ST_IDLE: begin
        if (pixel_valid) begin
          state_next = ctrle_pkg::ST_CALC;
        end
      end
      ctrle_pkg::ST_CALC: begin
        if (res_calc == '0 && !row_end) begin
          state_next = ctrle_pkg::ST_REM;
        end else begin
          state_next = ctrle_pkg::ST_UPDATE;
        end
      end
      ctrle_pkg::ST_REM: begin
        if (cnt == CNT_W'(1)) begin
          state_next = ctrle_pkg::ST_UPDATE;
        end
      end
      ctrle_pkg::ST_UPDATE: begin
        if (flush && be1 != '0) begin
          state_next = ctrle_pkg::ST_EOB;
        end else if (flush && zr1 != '0) begin
          state_next = ctrle_pkg::ST_RUN;
        end else if (res != '0) begin
          state_next = ctrle_pkg::ST_RESID;
        end else begin
          state_next = ctrle_pkg::ST_IDLE;
        end
      end
      ctrle_pkg::ST_EOB: begin
        if (slot_free) begin
          out_load = 1'b1;
          nxt_sym  = SW'(lim) + (SW'(1) << mlog) + SW'(digit);
          nxt_last = (sh_out == '0) && (zr == '0) && (res == '0);
          if (sh_out == '0) begin
            if (zr != '0) begin
              state_next = ctrle_pkg::ST_RUN;
            end else if (res != '0) begin
              state_next = ctrle_pkg::ST_RESID;
            end else begin
              state_next = ctrle_pkg::ST_IDLE;
            end
          end
        end
      end
      ctrle_pkg::ST_RUN: begin
        if (slot_free) begin
          out_load = 1'b1;
          nxt_sym  = SW'(lim) + SW'(digit);
          nxt_last = (sh_out == '0) && (res == '0);
          if (sh_out == '0) begin
            if (res != '0) begin
              state_next = ctrle_pkg::ST_RESID;
            end else begin
              state_next = ctrle_pkg::ST_IDLE;
            end
          end
        end
      end
      ctrle_pkg::ST_RESID: begin
        if (slot_free) begin
          out_load   = 1'b1;
          nxt_err    = (res >= SW'(lim));
          nxt_sym    = nxt_err ? '0 : res;
          nxt_last   = 1'b1;
          state_next = ctrle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ctrle_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state, configuration and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ctrle_pkg::ST_IDLE;
      image_width    <= ctrle_pkg::WIDTH_RST;
      image_height   <= ctrle_pkg::HEIGHT_RST;
      block_size     <= ctrle_pkg::BSIZE_RST;
      predictor_mode <= 1'b0;
      symbol_limit   <= ctrle_pkg::LIMIT_RST;
      run_radix_log  <= ctrle_pkg::LOG_RST;
      eob_radix_log  <= ctrle_pkg::LOG_RST;
      left_px        <= '0;
      upleft_px      <= '0;
      col            <= '0;
      row            <= '0;
      fill           <= '0;
      zr             <= '0;
      be             <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          ctrle_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[ctrle_pkg::WIDTH_W-1:0];
          ctrle_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[ctrle_pkg::HEIGHT_W-1:0];
          ctrle_pkg::REG_BLOCK_SIZE:     block_size     <= cfg_data[ctrle_pkg::BSIZE_W-1:0];
          ctrle_pkg::REG_PREDICTOR_MODE: predictor_mode <= cfg_data[0];
          ctrle_pkg::REG_SYMBOL_LIMIT:   symbol_limit   <= cfg_data[ctrle_pkg::LIMIT_W-1:0];
          ctrle_pkg::REG_RUN_RADIX_LOG:  run_radix_log  <= cfg_data[ctrle_pkg::LOG_W-1:0];
          ctrle_pkg::REG_EOB_RADIX_LOG:  eob_radix_log  <= cfg_data[ctrle_pkg::LOG_W-1:0];
          default: begin
          end
        endcase
      end

      if (state == ctrle_pkg::ST_CALC) begin
        // The written columns always form a prefix of the row store.
        if (last_px) begin
          fill <= '0;
        end else if ((CW+1)'(col) == fill) begin
          fill <= fill + (CW+1)'(1);
        end
        if (last_px) begin
          left_px   <= '0;
          upleft_px <= '0;
          col       <= '0;
          row       <= '0;
        end else if (row_end) begin
          left_px   <= '0;
          upleft_px <= '0;
          col       <= '0;
          row       <= row + ctrle_pkg::ROW_W'(1);
        end else begin
          left_px   <= pix;
          upleft_px <= d_px;
          col       <= col + CW'(1);
        end
      end

      if (state == ctrle_pkg::ST_UPDATE) begin
        zr <= zr1;
        be <= be1;
      end
      if (state == ctrle_pkg::ST_EOB && slot_free) begin
        be <= BW'(sh_out);
      end
      if (state == ctrle_pkg::ST_RUN && slot_free) begin
        zr <= ZW'(sh_out);
      end

      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Per-pixel payload and output word.
  always_ff @(posedge clk) begin
    if (state == ctrle_pkg::ST_IDLE && pixel_valid) begin
      pix     <= pixel;
      d_valid <= ((CW+1)'(col) < fill);
    end
    if (state == ctrle_pkg::ST_CALC) begin
      res       <= res_calc;
      row_end_r <= row_end;
      last_px_r <= last_px;
      rem       <= '0;
      qsh       <= col;
      cnt       <= CNT_W'(CW);
    end
    if (state == ctrle_pkg::ST_REM) begin
      rem <= rem_new;
      qsh <= qsh << 1;
      cnt <= cnt - CNT_W'(1);
    end
    if (out_load) begin
      symbol <= nxt_sym;
      error  <= nxt_err;
      last   <= nxt_last;
    end
  end

  // Row store: read as the pixel is taken, written once the residual is formed.
  always_ff @(posedge clk) begin
    if (state == ctrle_pkg::ST_IDLE && pixel_valid) begin
      row_rd <= row_mem[col];
    end
    if (state == ctrle_pkg::ST_CALC) begin
      row_mem[col] <= pix;
    end
  end

  // An error word carries a zero symbol and always closes its pixel's words.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> (symbol == '0) && last)
    else $error("error word with nonzero symbol or without last");

  // The column being coded never lies past the filled prefix of the row store.
  assert property (@(posedge clk) disable iff (rst)
    (state == ctrle_pkg::ST_CALC) |-> ((CW+1)'(col) <= fill))
    else $error("row store fill count behind the column");

  // Taking a pixel closes intake until its words are out.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("intake stayed open after a pixel was taken");

  // Words are only loaded from the emitting states.
  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (state == ctrle_pkg::ST_EOB || state == ctrle_pkg::ST_RUN ||
                  state == ctrle_pkg::ST_RESID))
    else $error("output word loaded outside an emitting state");

endmodule

/* hdl/ctrle_residual.sv */
// ============================================================================
// ctrle_residual
// Forms the residual of one pixel from its neighborhood, either by the
// corner transform with zig-zag mapping or by Paeth prediction modulo 32.
// ============================================================================
module ctrle_residual (
  input  ctrle_pkg::nbr_t                nbr,
  input  logic                           paeth,
  input  logic                           col0,
  output logic [ctrle_pkg::SYM_W-1:0]    res
);

  logic signed [10:0] sa, sb, sc, sd;
  logic signed [10:0] t, tt;
  logic signed [10:0] dpb, dpd, dpc;
  logic [10:0] pb, pd, pc;
  logic [ctrle_pkg::PIX_W-1:0] pred;
  logic [ctrle_pkg::PIX_W-1:0] diff;
  logic [ctrle_pkg::SYM_W-1:0] zz;

  assign sa = $signed({3'b000, nbr.a});
  assign sb = $signed({3'b000, nbr.b});
  assign sc = $signed({3'b000, nbr.c});
  assign sd = $signed({3'b000, nbr.d});

  // Corner transform; the zig-zag of a negative value is the complement of 2t.
  assign t  = col0 ? (sa - sd) : (sa - sb - sd + sc);
  assign tt = t <<< 1;
  assign zz = t[10] ? ~tt : tt;

  // Paeth distances from p = b + d - c.
  assign dpb = sd - sc;
  assign dpd = sb - sc;
  assign dpc = sb + sd - sc - sc;
  assign pb  = dpb[10] ? -dpb : dpb;
  assign pd  = dpd[10] ? -dpd : dpd;
  assign pc  = dpc[10] ? -dpc : dpc;

  always_comb begin
    if (col0) begin
      pred = nbr.d;
    end else if (pb <= pd && pb <= pc) begin
      pred = nbr.b;
    end else if (pd <= pc) begin
      pred = nbr.d;
    end else begin
      pred = nbr.c;
    end
  end

  assign diff = nbr.a - pred;
  assign res  = paeth ? ctrle_pkg::SYM_W'(diff[ctrle_pkg::MOD_W-1:0]) : zz;

endmodule
